[rtl/icfa_pkg.sv]
package icfa_pkg;

	localparam int INIT_COUNT_DEF   = 8;
	localparam int CORDIC_ITERS_DEF = 16;

	localparam int PCW   = 8;
	localparam int CHW   = 4;
	localparam int IDW   = 11;
	localparam int PLW   = 64;
	localparam int QW    = 16;
	localparam int PKW   = 48;
	localparam int CFGW  = 11;
	localparam int CIXW  = 3;
	localparam int PRW   = 32;
	localparam int OW    = 34;
	localparam int XW    = 38;
	localparam int ZW    = 34;
	localparam int SW    = 6;
	localparam int BAMW  = 18;
	localparam int MAGW  = 36;
	localparam int HPW   = 52;
	localparam int TABLE_LEN = 24;
	localparam int TIW   = 5;
	localparam int NUM_PROD = 10;
	localparam int PSW   = 4;

	localparam logic [CIXW-1:0] REG_QUAT_CH  = 3'd0;
	localparam logic [CIXW-1:0] REG_GYRO_CH  = 3'd1;
	localparam logic [CIXW-1:0] REG_ACCEL_CH = 3'd2;
	localparam logic [CIXW-1:0] REG_QUAT_ID  = 3'd3;
	localparam logic [CIXW-1:0] REG_GYRO_ID  = 3'd4;
	localparam logic [CIXW-1:0] REG_ACCEL_ID = 3'd5;

	localparam logic [1:0] COR_ROLL  = 2'd0;
	localparam logic [1:0] COR_PITCH = 2'd1;
	localparam logic [1:0] COR_YAW   = 2'd2;

	localparam logic [PSW-1:0] PROD_LAST = PSW'(NUM_PROD - 1);

	localparam logic [15:0] KINV_Q16 = 16'd39797;
	localparam logic signed [BAMW-1:0] HALF_PI_BAM = 18'sd16384;

	localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic           decode;
		logic           mul_en;
		logic [PSW-1:0] mul_sel;
		logic           form;
		logic           cor_start;
		logic [1:0]     cor_sel;
		logic           roll_save;
		logic           h_mul;
		logic           h_shift;
		logic           pitch_save;
		logic           yaw_save;
		logic           load_req;
		logic           load_sample;
	} icfa_ctl_t;

	typedef struct packed {
		logic dec_req;
		logic dec_sample;
		logic cor_done;
		logic out_free;
	} icfa_stat_t;

endpackage

[rtl/icfa_cordic.sv]
module icfa_cordic import icfa_pkg::*; #(
	parameter int ITERS = CORDIC_ITERS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [OW-1:0]   x_in,
	input  logic signed [OW-1:0]   y_in,
	output logic                   done,
	output logic signed [BAMW-1:0] angle,
	output logic signed [XW-1:0]   mag,
	output logic [SW-1:0]          shift
);

	localparam int IW = $clog2(ITERS);
	localparam logic [IW-1:0] LAST = IW'(ITERS - 1);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_NORM = 2'd1;
	localparam logic [1:0] C_ITER = 2'd2;
	localparam logic [1:0] C_DONE = 2'd3;

	localparam logic signed [XW-1:0] LIM   = XW'(64'sd4294967296);
	localparam logic signed [XW-1:0] LIM8  = XW'(64'sd16777216);
	localparam logic signed [ZW-1:0] PI_Z  = ZW'(64'sd2147483648);
	localparam logic signed [ZW:0]   RND   = (ZW+1)'(32768);

	logic [1:0]           state_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [SW-1:0]        s_q;
	logic [IW-1:0]        i_q;

	logic signed [XW-1:0] dx, dy;
	logic signed [ZW-1:0] ta;
	logic                 inr, inr8;
	logic signed [ZW:0]   zsum;

	always_comb begin
		dx   = y_q >>> i_q;
		dy   = x_q >>> i_q;
		ta   = signed'({2'b00, ATAN_TAB[TIW'(i_q)]});
		inr  = (x_q > -LIM) && (x_q < LIM) && (y_q > -LIM) && (y_q < LIM);
		inr8 = (x_q > -LIM8) && (x_q < LIM8) && (y_q > -LIM8) && (y_q < LIM8);
		zsum = (ZW+1)'(z_q) + RND;
	end

	assign done  = (state_q == C_DONE);
	assign angle = zsum[16 +: BAMW];
	assign mag   = x_q;
	assign shift = s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= (x_in == '0 && y_in == '0) ? C_DONE : C_NORM;
					end
				end
				C_NORM: begin
					if (!inr) begin
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (i_q == LAST) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					x_q <= XW'(x_in);
					y_q <= XW'(y_in);
					z_q <= '0;
					s_q <= '0;
					i_q <= '0;
				end
			end
			C_NORM: begin
				if (inr8) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
					s_q <= s_q + SW'(8);
				end else if (inr) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
					s_q <= s_q + SW'(1);
				end else if (x_q < 0) begin
					// turn the vector by pi into the right half plane
					z_q <= (y_q >= 0) ? PI_Z : -PI_Z;
					x_q <= -x_q;
					y_q <= -y_q;
				end
			end
			C_ITER: begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + ta;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - ta;
				end
				i_q <= i_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/icfa_dp.sv]
module icfa_dp import icfa_pkg::*; #(
	parameter int INIT_COUNT   = INIT_COUNT_DEF,
	parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  icfa_ctl_t              ctl,
	output icfa_stat_t             stat,
	input  logic                   cfg_we,
	input  logic [CIXW-1:0]        cfg_index,
	input  logic [CFGW-1:0]        cfg_data,
	input  logic                   cmd,
	input  logic [CHW-1:0]         channel,
	input  logic [IDW-1:0]         msg_id,
	input  logic [PLW-1:0]         payload,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   kind,
	output logic [IDW-1:0]         request_id,
	output logic signed [QW-1:0]   quat_w,
	output logic signed [QW-1:0]   quat_x,
	output logic signed [QW-1:0]   quat_y,
	output logic signed [QW-1:0]   quat_z,
	output logic [PKW-1:0]         gyro_packed,
	output logic [PKW-1:0]         accel_packed,
	output logic signed [QW-1:0]   roll_angle,
	output logic signed [QW-1:0]   pitch_angle,
	output logic signed [QW-1:0]   yaw_angle
);

	logic [CHW-1:0] quat_ch_q, gyro_ch_q, accel_ch_q;
	logic [IDW-1:0] quat_id_q, gyro_id_q, accel_id_q;

	logic [PCW-1:0] poll_count_q;
	logic [2:0]     flags_q;
	logic [QW-1:0]  quat_q  [4];
	logic [QW-1:0]  gyro_q  [3];
	logic [QW-1:0]  accel_q [3];
	logic [IDW-1:0] req_id_q;

	logic signed [PRW-1:0] prod_q [NUM_PROD];
	logic signed [OW-1:0]  rs_q, rc_q, ys_q, yc_q, ps_q, h_q;
	logic [HPW-1:0]        h_prod_q;
	logic signed [QW-1:0]  roll_q, pitch_q, yaw_q;

	logic hit_q, hit_g, hit_a, open, latch;
	logic [2:0] nf;
	logic [IDW-1:0] sel_id;
	logic signed [QW-1:0] mul_a, mul_b;
	logic signed [OW-1:0] pe [NUM_PROD];
	logic signed [OW-1:0] cx, cy;
	logic [HPW-1:0] h_shifted;
	logic signed [BAMW-1:0] p_clamped;

	logic                   cor_done;
	logic signed [BAMW-1:0] cor_angle;
	logic signed [XW-1:0]   cor_mag;
	logic [SW-1:0]          cor_shift;

	// message decode
	always_comb begin
		hit_q = (channel == quat_ch_q);
		hit_g = !hit_q && (channel == gyro_ch_q);
		hit_a = !hit_q && !hit_g && (channel == accel_ch_q);
		open  = (poll_count_q < PCW'(INIT_COUNT));
		latch = cmd && (msg_id != '0) && !open;
		nf    = flags_q | {hit_a, hit_g, hit_q};
		if (hit_q) begin
			sel_id = quat_id_q;
		end else if (hit_g) begin
			sel_id = gyro_id_q;
		end else begin
			sel_id = accel_id_q;
		end
		stat.dec_req    = !cmd && open && (hit_q || hit_g || hit_a);
		stat.dec_sample = latch && (&nf);
		stat.cor_done   = cor_done;
		stat.out_free   = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_ch_q  <= CHW'(0);
			gyro_ch_q  <= CHW'(1);
			accel_ch_q <= CHW'(2);
			quat_id_q  <= '0;
			gyro_id_q  <= '0;
			accel_id_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUAT_CH:  quat_ch_q  <= cfg_data[CHW-1:0];
				REG_GYRO_CH:  gyro_ch_q  <= cfg_data[CHW-1:0];
				REG_ACCEL_CH: accel_ch_q <= cfg_data[CHW-1:0];
				REG_QUAT_ID:  quat_id_q  <= cfg_data[IDW-1:0];
				REG_GYRO_ID:  gyro_id_q  <= cfg_data[IDW-1:0];
				REG_ACCEL_ID: accel_id_q <= cfg_data[IDW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_count_q <= '0;
			flags_q      <= '0;
			for (int k = 0; k < 4; k++) quat_q[k] <= '0;
			for (int k = 0; k < 3; k++) begin
				gyro_q[k]  <= '0;
				accel_q[k] <= '0;
			end
		end else if (ctl.decode) begin
			if (!cmd) begin
				if (open) begin
					poll_count_q <= poll_count_q + PCW'(1);
				end
			end else if (msg_id == '0) begin
				if (!hit_q) begin
					flags_q[1:0] <= 2'b00;
				end
			end else if (latch) begin
				if (hit_q) begin
					for (int k = 0; k < 4; k++) quat_q[k] <= payload[PLW-1-QW*k -: QW];
				end
				if (hit_g) begin
					for (int k = 0; k < 3; k++) gyro_q[k] <= payload[PLW-1-QW*k -: QW];
				end
				if (hit_a) begin
					for (int k = 0; k < 3; k++) accel_q[k] <= payload[PLW-1-QW*k -: QW];
				end
				flags_q <= (&nf) ? 3'b000 : nf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.decode) begin
			req_id_q <= sel_id;
		end
	end

	// product operands: ww xx yy zz wx yz wz xy wy xz
	always_comb begin
		unique case (ctl.mul_sel)
			4'd0:    begin mul_a = quat_q[0]; mul_b = quat_q[0]; end
			4'd1:    begin mul_a = quat_q[1]; mul_b = quat_q[1]; end
			4'd2:    begin mul_a = quat_q[2]; mul_b = quat_q[2]; end
			4'd3:    begin mul_a = quat_q[3]; mul_b = quat_q[3]; end
			4'd4:    begin mul_a = quat_q[0]; mul_b = quat_q[1]; end
			4'd5:    begin mul_a = quat_q[2]; mul_b = quat_q[3]; end
			4'd6:    begin mul_a = quat_q[0]; mul_b = quat_q[3]; end
			4'd7:    begin mul_a = quat_q[1]; mul_b = quat_q[2]; end
			4'd8:    begin mul_a = quat_q[0]; mul_b = quat_q[2]; end
			default: begin mul_a = quat_q[1]; mul_b = quat_q[3]; end
		endcase
		for (int k = 0; k < NUM_PROD; k++) pe[k] = OW'(prod_q[k]);
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q[ctl.mul_sel] <= mul_a * mul_b;
		end
		if (ctl.form) begin
			rs_q <= (pe[4] + pe[5]) <<< 1;
			rc_q <= pe[0] - pe[1] - pe[2] + pe[3];
			ys_q <= (pe[6] + pe[7]) <<< 1;
			yc_q <= pe[0] + pe[1] - pe[2] - pe[3];
			ps_q <= (pe[8] - pe[9]) <<< 1;
		end
		if (ctl.h_mul) begin
			h_prod_q <= cor_mag[MAGW-1:0] * KINV_Q16;
		end
		if (ctl.h_shift) begin
			h_q <= signed'(h_shifted[OW-1:0]);
		end
		if (ctl.roll_save) begin
			roll_q <= cor_angle[QW-1:0];
		end
		if (ctl.pitch_save) begin
			pitch_q <= p_clamped[QW-1:0];
		end
		if (ctl.yaw_save) begin
			yaw_q <= cor_angle[QW-1:0];
		end
	end

	always_comb begin
		h_shifted = h_prod_q >> (SW'(16) + cor_shift);
		if (cor_angle > HALF_PI_BAM) begin
			p_clamped = HALF_PI_BAM;
		end else if (cor_angle < -HALF_PI_BAM) begin
			p_clamped = -HALF_PI_BAM;
		end else begin
			p_clamped = cor_angle;
		end
		unique case (ctl.cor_sel)
			COR_ROLL:  begin cx = rc_q; cy = rs_q; end
			COR_PITCH: begin cx = h_q;  cy = ps_q; end
			default:   begin cx = yc_q; cy = ys_q; end
		endcase
	end

	icfa_cordic #(
		.ITERS(CORDIC_ITERS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.cor_start),
		.x_in  (cx),
		.y_in  (cy),
		.done  (cor_done),
		.angle (cor_angle),
		.mag   (cor_mag),
		.shift (cor_shift)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.load_req || ctl.load_sample) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			kind         <= 1'b0;
			request_id   <= req_id_q;
			quat_w       <= '0;
			quat_x       <= '0;
			quat_y       <= '0;
			quat_z       <= '0;
			gyro_packed  <= '0;
			accel_packed <= '0;
			roll_angle   <= '0;
			pitch_angle  <= '0;
			yaw_angle    <= '0;
		end else if (ctl.load_sample) begin
			kind         <= 1'b1;
			request_id   <= '0;
			quat_w       <= quat_q[0];
			quat_x       <= quat_q[1];
			quat_y       <= quat_q[2];
			quat_z       <= quat_q[3];
			gyro_packed  <= {gyro_q[0], gyro_q[1], gyro_q[2]};
			accel_packed <= {accel_q[0], accel_q[1], accel_q[2]};
			roll_angle   <= roll_q;
			pitch_angle  <= pitch_q;
			yaw_angle    <= yaw_q;
		end
	end

endmodule

[rtl/icfa_ctrl.sv]
module icfa_ctrl import icfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  icfa_stat_t stat,
	output icfa_ctl_t  ctl
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_REQ  = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_FORM = 4'd3;
	localparam logic [3:0] S_RST  = 4'd4;
	localparam logic [3:0] S_RWT  = 4'd5;
	localparam logic [3:0] S_HMUL = 4'd6;
	localparam logic [3:0] S_HSHF = 4'd7;
	localparam logic [3:0] S_PST  = 4'd8;
	localparam logic [3:0] S_PWT  = 4'd9;
	localparam logic [3:0] S_YST  = 4'd10;
	localparam logic [3:0] S_YWT  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0]     state_q, state_d;
	logic [PSW-1:0] mul_q;

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		ctl.mul_sel = mul_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.decode = in_valid;
				if (in_valid) begin
					if (stat.dec_req) begin
						state_d = S_REQ;
					end else if (stat.dec_sample) begin
						state_d = S_MUL;
					end
				end
			end
			S_REQ: begin
				if (stat.out_free) begin
					ctl.load_req = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MUL: begin
				ctl.mul_en = 1'b1;
				if (mul_q == PROD_LAST) begin
					state_d = S_FORM;
				end
			end
			S_FORM: begin
				ctl.form = 1'b1;
				state_d = S_RST;
			end
			S_RST: begin
				ctl.cor_start = 1'b1;
				ctl.cor_sel = COR_ROLL;
				state_d = S_RWT;
			end
			S_RWT: begin
				if (stat.cor_done) begin
					ctl.roll_save = 1'b1;
					state_d = S_HMUL;
				end
			end
			S_HMUL: begin
				ctl.h_mul = 1'b1;
				state_d = S_HSHF;
			end
			S_HSHF: begin
				ctl.h_shift = 1'b1;
				state_d = S_PST;
			end
			S_PST: begin
				ctl.cor_start = 1'b1;
				ctl.cor_sel = COR_PITCH;
				state_d = S_PWT;
			end
			S_PWT: begin
				if (stat.cor_done) begin
					ctl.pitch_save = 1'b1;
					state_d = S_YST;
				end
			end
			S_YST: begin
				ctl.cor_start = 1'b1;
				ctl.cor_sel = COR_YAW;
				state_d = S_YWT;
			end
			S_YWT: begin
				if (stat.cor_done) begin
					ctl.yaw_save = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					ctl.load_sample = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mul_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL) begin
				mul_q <= (mul_q == PROD_LAST) ? '0 : mul_q + PSW'(1);
			end
		end
	end

endmodule

[rtl/imu_can_frame_assembler_euler_top.sv]
// channel  direction  handshake               beat contents
// in       input      in_valid / in_ready     cmd, channel, msg_id, payload
// out      output     out_valid / out_ready   kind, request_id, quaternion, gyro, accel, angles
// cfg      input      cfg_we                  cfg_index, cfg_data
//
// polls, empty and ignored messages are taken in the idle state; a poll request then waits in S_REQ to load its reply
// a completed sample runs the products, then the single shared cordic unit
// for roll, pitch and yaw in turn
// a zero vector skips its cordic pass and goes straight to done
// a finished beat waits in the output register while the next item is taken
// arst_n clears flags, poll count, stores, config registers, control state and out_valid to their reset values
module imu_can_frame_assembler_euler_top import icfa_pkg::*; #(
	parameter int INIT_COUNT   = INIT_COUNT_DEF,
	parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [CHW-1:0]       channel,
	input  logic [IDW-1:0]       msg_id,
	input  logic [PLW-1:0]       payload,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 kind,
	output logic [IDW-1:0]       request_id,
	output logic signed [QW-1:0] quat_w,
	output logic signed [QW-1:0] quat_x,
	output logic signed [QW-1:0] quat_y,
	output logic signed [QW-1:0] quat_z,
	output logic [PKW-1:0]       gyro_packed,
	output logic [PKW-1:0]       accel_packed,
	output logic signed [QW-1:0] roll_angle,
	output logic signed [QW-1:0] pitch_angle,
	output logic signed [QW-1:0] yaw_angle,
	input  logic                 cfg_we,
	input  logic [CIXW-1:0]      cfg_index,
	input  logic [CFGW-1:0]      cfg_data
);

	icfa_ctl_t  ctl;
	icfa_stat_t stat;

	icfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.ctl     (ctl)
	);

	icfa_dp #(
		.INIT_COUNT  (INIT_COUNT),
		.CORDIC_ITERS(CORDIC_ITERS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.channel     (channel),
		.msg_id      (msg_id),
		.payload     (payload),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.request_id  (request_id),
		.quat_w      (quat_w),
		.quat_x      (quat_x),
		.quat_y      (quat_y),
		.quat_z      (quat_z),
		.gyro_packed (gyro_packed),
		.accel_packed(accel_packed),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle)
	);

endmodule
